FILE: rtl/core/b2d_pkg.sv
// Shared types and constants for the binary to ASCII decimal converter.
package b2d_pkg;

    localparam int unsigned NUM_PLACES = 4;
    localparam int unsigned MAG_W      = 16;
    localparam int unsigned DIG_W      = 4;
    localparam int unsigned POS_W      = $clog2(NUM_PLACES + 1);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_PLACES);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    localparam int unsigned PLACE_WEIGHT [NUM_PLACES] = '{10000, 1000, 100, 10};

    // One item in flight: sign, the digits found so far, the remainder.
    typedef struct packed {
        logic                             neg;
        logic [NUM_PLACES-1:0][DIG_W-1:0] digs;
        logic [MAG_W-1:0]                 mag;
    } b2d_item_t;

endpackage

FILE: rtl/core/b2d_prep.sv
// Input stage: byte/word select, sign detect and magnitude.
module b2d_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [15:0]       value,
    input  logic              is_wide,
    input  logic              is_signed,
    output logic              out_valid,
    input  logic              out_stall,
    output b2d_pkg::b2d_item_t out_item
);
    import b2d_pkg::*;

    logic      vld_reg;
    b2d_item_t item_reg;
    b2d_item_t item_next;
    logic      neg;
    logic [7:0] byte_neg;

    assign in_stall = vld_reg && out_stall;

    always_comb
    begin
        neg       = is_signed && (is_wide ? value[15] : value[7]);
        byte_neg  = 8'(~value[7:0] + 8'd1);
        item_next = '0;
        item_next.neg = neg;
        if (is_wide)
        begin
            item_next.mag = neg ? 16'(~value + 16'd1) : value;
        end
        else
        begin
            item_next.mag = {8'd0, (neg ? byte_neg : value[7:0])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/core/b2d_digits.sv
// Four pipelined digit stages: 10000s, 1000s, 100s and 10s.
module b2d_digits (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  b2d_pkg::b2d_item_t in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output b2d_pkg::b2d_item_t out_item
);
    import b2d_pkg::*;

    b2d_item_t stg_item  [NUM_PLACES+1];
    logic      stg_valid [NUM_PLACES+1];
    logic      stg_stall [NUM_PLACES+1];

    assign stg_item[0]  = in_item;
    assign stg_valid[0] = in_valid;
    assign in_stall     = stg_stall[0];
    assign stg_stall[NUM_PLACES] = out_stall;

    for (genvar g = 0; g < NUM_PLACES; g++)
    begin : g_place
        logic       vld_reg;
        b2d_item_t  item_reg;
        b2d_item_t  item_next;
        logic [DIG_W-1:0] dig;
        logic [MAG_W:0]   sub;

        assign stg_stall[g] = vld_reg && stg_stall[g+1];

        // Remainder is below ten times this weight, so the digit is the
        // highest multiple that still fits.
        always_comb
        begin
            dig = '0;
            sub = '0;
            for (int k = 1; k <= 9; k++)
            begin
                if ({1'b0, stg_item[g].mag} >= (MAG_W+1)'(k * PLACE_WEIGHT[g]))
                begin
                    dig = DIG_W'(k);
                    sub = (MAG_W+1)'(k * PLACE_WEIGHT[g]);
                end
            end
            item_next         = stg_item[g];
            item_next.digs[g] = dig;
            item_next.mag     = MAG_W'({1'b0, stg_item[g].mag} - sub);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (!stg_stall[g])
            begin
                vld_reg <= stg_valid[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!stg_stall[g] && stg_valid[g])
            begin
                item_reg <= item_next;
            end
        end

        assign stg_item[g+1]  = item_reg;
        assign stg_valid[g+1] = vld_reg;
    end

    assign out_valid = stg_valid[NUM_PLACES];
    assign out_item  = stg_item[NUM_PLACES];

endmodule

FILE: rtl/core/b2d_emit.sv
// Character serializer: sign, then digits from the first nonzero one.
module b2d_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  b2d_pkg::b2d_item_t in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         text_char,
    output logic               last_char
);
    import b2d_pkg::*;

    logic             busy_reg;
    logic             neg_reg;
    logic [POS_W-1:0] pos_reg;
    logic [DIG_W-1:0] digs_reg [NUM_PLACES+1];
    logic [POS_W-1:0] first_pos;
    logic             take;
    logic             fin;
    logic             load;

    // First nonzero digit; the ones digit is always printed.
    always_comb
    begin
        first_pos = LAST_POS;
        for (int p = NUM_PLACES - 1; p >= 0; p--)
        begin
            if (in_item.digs[p] != '0)
            begin
                first_pos = POS_W'(p);
            end
        end
    end

    assign take     = busy_reg && !out_stall;
    assign fin      = take && !neg_reg && (pos_reg == LAST_POS);
    assign in_stall = busy_reg && !fin;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            neg_reg  <= 1'b0;
            pos_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            neg_reg  <= in_item.neg;
            pos_reg  <= first_pos;
        end
        else if (fin)
        begin
            busy_reg <= 1'b0;
        end
        else if (take)
        begin
            if (neg_reg)
            begin
                neg_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int p = 0; p < NUM_PLACES; p++)
            begin
                digs_reg[p] <= in_item.digs[p];
            end
            digs_reg[NUM_PLACES] <= in_item.mag[DIG_W-1:0];
        end
    end

    assign out_valid = busy_reg;
    assign text_char = neg_reg ? ASCII_MINUS : 8'(ASCII_ZERO + {4'd0, digs_reg[pos_reg]});
    assign last_char = !neg_reg && (pos_reg == LAST_POS);

endmodule

FILE: rtl/core/binary_to_decimal_ascii_text.sv
// Top level of the binary to ASCII decimal converter.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------
//  input   | value[15:0], is_wide, is_signed         | in_valid / in_stall
//  output  | text_char[7:0], last_char               | out_valid / out_stall
//
// The first character reaches the output by way of the prep register, the four
// digit stages and the serializer load, after the input accept. The serializer
// sends one character a cycle while out_stall is low, 1 to 6 per item. The
// pipeline holds up to six items, one of them being sent.
// Reset clears all valid bits; no item survives it.
// A stall freezes the stage that holds it and backs up only as far as needed.
module binary_to_decimal_ascii_text (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] value,
    input  logic        is_wide,
    input  logic        is_signed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  text_char,
    output logic        last_char
);
    import b2d_pkg::*;

    b2d_item_t prep_item;
    logic      prep_valid;
    logic      prep_stall;
    b2d_item_t dig_item;
    logic      dig_valid;
    logic      dig_stall;

    b2d_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .is_wide   (is_wide),
        .is_signed (is_signed),
        .out_valid (prep_valid),
        .out_stall (prep_stall),
        .out_item  (prep_item)
    );

    b2d_digits u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_stall  (prep_stall),
        .in_item   (prep_item),
        .out_valid (dig_valid),
        .out_stall (dig_stall),
        .out_item  (dig_item)
    );

    b2d_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dig_valid),
        .in_stall  (dig_stall),
        .in_item   (dig_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

endmodule

FILE: verif/tb_binary_to_decimal_ascii_text.sv
// Testbench for the binary to ASCII decimal converter: predicted text vs. DUT output.
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii_text;

    import b2d_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 129;  // per phase

    // Expected characters of every accepted number, oldest first.
    class decimal_text_board;
        logic [7:0]  want_char [$];
        bit          want_last [$];
        int unsigned place_div [4] = '{10000, 1000, 100, 10};
        int          fails;

        function new();
            fails = 0;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            fails++;
        endtask

        function int pending();
            return want_char.size();
        endfunction

        function void push_char(input logic [7:0] ch, input bit last);
            want_char.push_back(ch);
            want_last.push_back(last);
        endfunction

        // Converts one accepted number into the characters it must print.
        function void note_number(input logic [15:0] v, input logic wide, input logic sgn);
            logic [15:0] mag;
            logic [15:0] digit;
            bit          started;
            int          first;
            mag     = wide ? v : {8'h00, v[7:0]};
            started = 1'b0;
            first   = wide ? 0 : 2;
            if (sgn && (wide ? mag[15] : mag[7]))
            begin
                push_char(ASCII_MINUS, 1'b0);
                mag = -mag;
                if (!wide)
                    mag = {8'h00, mag[7:0]};
            end
            for (int p = first; p < 4; p++)
            begin
                digit = 16'(mag / place_div[p]);
                mag   = 16'(mag % place_div[p]);
                if (started || digit != 0)
                begin
                    push_char(ASCII_ZERO + digit[7:0], 1'b0);
                    started = 1'b1;
                end
            end
            push_char(ASCII_ZERO + mag[7:0], 1'b1);
        endfunction

        task check_char(input logic [7:0] ch, input logic last);
            logic [7:0] exp_ch;
            bit         exp_last;
            if (want_char.size() == 0)
            begin
                report($sformatf("unexpected char 0x%02h last=%b", ch, last));
            end
            else
            begin
                exp_ch   = want_char.pop_front();
                exp_last = want_last.pop_front();
                if (ch !== exp_ch)
                    report($sformatf("text_char 0x%02h, want 0x%02h", ch, exp_ch));
                if (last !== exp_last)
                    report($sformatf("last_char %b, want %b (char 0x%02h)",
                                     last, exp_last, exp_ch));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] value;
    logic        is_wide;
    logic        is_signed;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  text_char;
    logic        last_char;

    decimal_text_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count = 0;

    binary_to_decimal_ascii_text u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .is_wide   (is_wide),
        .is_signed (is_signed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Output side: take chars, stall at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_char(text_char, last_char);
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Holds valid until accepted; drops it only for a gap before the next item.
    task automatic send_number(input logic [15:0] v, input logic w, input logic s);
        in_valid  <= 1'b1;
        value     <= v;
        is_wide   <= w;
        is_signed <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_number(v, w, s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_random_number();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(3))
            0: v = v;
            1: v = 16'($urandom_range(0, 9));
            2: v = 16'($urandom_range(0, 999));
            default: v = 16'($urandom_range(0, 20000));
        endcase
        send_number(v, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    initial
    begin
        board         = new();
        send_idle_pct = 11;
        recv_idle_pct = 56;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        value     <= 16'h0000;
        is_wide   <= 1'b0;
        is_signed <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte mode
        send_number(16'h0000, 1'b0, 1'b0);
        send_number(16'h00FF, 1'b0, 1'b0);
        send_number(16'h0080, 1'b0, 1'b1);  // -128
        send_number(16'h00FF, 1'b0, 1'b1);
        send_number(16'h007F, 1'b0, 1'b1);
        send_number(16'hAB05, 1'b0, 1'b0);  // high byte ignored
        send_number(16'hFF00, 1'b0, 1'b1);
        send_number(16'h0064, 1'b0, 1'b1);
        send_number(16'h009C, 1'b0, 1'b1);
        send_number(16'h0080, 1'b0, 1'b0);
        // word mode
        send_number(16'h0000, 1'b1, 1'b0);
        send_number(16'hFFFF, 1'b1, 1'b0);
        send_number(16'h8000, 1'b1, 1'b1);  // -32768
        send_number(16'hFFFF, 1'b1, 1'b1);
        send_number(16'h7FFF, 1'b1, 1'b1);
        send_number(16'h8000, 1'b1, 1'b0);
        send_number(16'd10000, 1'b1, 1'b0);
        send_number(16'd9999, 1'b1, 1'b0);
        send_number(16'd1000, 1'b1, 1'b1);
        send_number(16'd100, 1'b1, 1'b0);
        send_number(16'd10, 1'b1, 1'b0);
        send_number(16'd9, 1'b1, 1'b1);
        send_number(16'h0000, 1'b1, 1'b1);
        send_number(16'hD8F0, 1'b1, 1'b1);  // -10000

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++)
                send_random_number();
        end

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
